// ===== rtl/tcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_pkg: shared types and constants of the text chunk frame encoder
// Item and result payloads, the command passed from front to back, and the
// fixed frame constants.
// ----------------------------------------------------------------------------
package tcfe_pkg;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_META  = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_META_LONG  = 2'd1;
    localparam logic [1:0] ST_NO_ROOM    = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    // frame constants
    localparam logic [7:0] MAGIC_BYTE    = 8'hA5;
    localparam logic [7:0] VERSION_BYTE  = 8'h02;
    localparam logic [7:0] HEADER_FIELDS = 8'd4;
    localparam int         HEAD_BYTES    = 8;   // fixed bytes before metadata

    // command queue
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] event_type;
        logic [7:0] module_id;
        logic [7:0] text_length;
        logic [7:0] metadata_length;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic [1:0] status;
        logic       last;
    } result_t;

    // one unit of work for the back end
    typedef struct packed {
        logic       is_err;
        logic [1:0] status;
        logic       do_head;
        logic       has_text;
        logic       do_check;
        logic [7:0] text_byte;
        logic [7:0] event_type;
        logic [7:0] module_id;
        logic [7:0] offset;
        logic [7:0] total;
        logic [7:0] chunk;
        logic [7:0] meta_len;
    } cmd_t;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } meta_wr_t;

endpackage

// ===== rtl/text_chunk_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_chunk_frame_encoder: splits a text message into checksummed frames
// Start, metadata and text items in; frame bytes with status out.
// ----------------------------------------------------------------------------
// A start item announces a message (type, module, text length, metadata
// length); metadata bytes follow, then text bytes. Text is cut into chunks
// of at most FRAME_BYTES-9-metadata bytes, each sent as one frame: A5, 02,
// type, payload length, module, offset, total, chunk length, the metadata,
// the chunk text and an XOR checksum of the preceding bytes. The front end
// takes one item per cycle while its command queue has room; a text byte
// that opens a chunk makes the emitter load the command, then send the
// header (8 fixed bytes and metadata), the byte, and the checksum when
// the chunk is one byte: at most FRAME_BYTES bytes. Other text bytes send
// their byte and, at a chunk's end, the checksum. The output stage moves
// one byte per cycle while pop is held, so the emitter sets the rate.
// Metadata bytes of a new message are held off (full high) until every
// frame of the previous message has left the emitter, since the emitter
// reads the metadata store while it builds each frame header.
// ----------------------------------------------------------------------------
module text_chunk_frame_encoder #(
    parameter int FRAME_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // item side: transfer on push && !full
    input  logic              push,
    output logic              full,
    input  tcfe_pkg::item_t   item,
    // result side: transfer on pop && !empty
    output logic              empty,
    input  logic              pop,
    output tcfe_pkg::result_t result
);

    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               cmd_push;
    logic               back_idle;
    tcfe_pkg::cmd_t     cmd_in;
    tcfe_pkg::cmd_t     cmd_out;
    tcfe_pkg::meta_wr_t meta_wr;

    // classifier: phase tracking, metadata writes, command issue
    tcfe_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .back_idle (back_idle),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in),
        .meta_wr   (meta_wr)
    );

    // decouples item intake from byte emission
    tcfe_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (q_pop),
        .rd_data (cmd_out),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // emitter: one frame byte per cycle into the output register while it has room
    tcfe_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .meta_wr   (meta_wr),
        .q_empty   (q_empty),
        .q_data    (cmd_out),
        .q_pop     (q_pop),
        .back_idle (back_idle),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/tcfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_front: item classifier
// Accepts items, tracks the message phase, writes metadata and issues
// frame commands to the command queue.
// ----------------------------------------------------------------------------
module tcfe_front #(
    parameter int FRAME_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tcfe_pkg::item_t   item,
    input  logic              q_full,
    input  logic              q_empty,
    input  logic              back_idle,
    output logic              cmd_push,
    output tcfe_pkg::cmd_t    cmd_data,
    output tcfe_pkg::meta_wr_t meta_wr
);

    localparam int META_MAX = FRAME_BYTES - 9;
    localparam int META_W   = $clog2(META_MAX + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_META = 2'd1;
    localparam logic [1:0] PH_TEXT = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        module_reg, module_next;
    logic [7:0]        total_reg, total_next;
    logic [META_W-1:0] meta_exp_reg, meta_exp_next;
    logic [META_W-1:0] meta_cnt_reg, meta_cnt_next;
    logic [7:0]        offset_reg, offset_next;
    logic [META_W-1:0] chunk_left_reg, chunk_left_next;

    logic              accept;
    logic [META_W-1:0] room;
    logic [7:0]        room8;
    logic [7:0]        rest;
    logic [7:0]        chunk;
    logic [META_W-1:0] cl_cur;
    logic [META_W-1:0] cl_after;
    logic [8:0]        offset_inc;
    logic [META_W-1:0] meta_cnt_inc;

    // metadata writes wait until the back end no longer reads the store
    assign full   = q_full || ((phase_reg == PH_META) && !(q_empty && back_idle));
    assign accept = push && !full;

    assign room         = META_W'(META_MAX) - meta_exp_reg;
    assign room8        = 8'(room);
    assign rest         = total_reg - offset_reg;
    assign chunk        = (rest < room8) ? rest : room8;
    assign cl_cur       = (chunk_left_reg == '0) ? META_W'(chunk) : chunk_left_reg;
    assign cl_after     = (cl_cur != '0) ? cl_cur - META_W'(1) : '0;
    assign offset_inc   = {1'b0, offset_reg} + 9'd1;
    assign meta_cnt_inc = meta_cnt_reg + META_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        module_next     = module_reg;
        total_next      = total_reg;
        meta_exp_next   = meta_exp_reg;
        meta_cnt_next   = meta_cnt_reg;
        offset_next     = offset_reg;
        chunk_left_next = chunk_left_reg;
        cmd_push        = 1'b0;
        cmd_data        = '0;
        cmd_data.event_type = type_reg;
        cmd_data.module_id  = module_reg;
        cmd_data.total      = total_reg;
        cmd_data.offset     = offset_reg;
        cmd_data.meta_len   = 8'(meta_exp_reg);
        meta_wr         = '0;
        if (accept)
        begin
            case (item.kind)
                tcfe_pkg::KIND_START:
                begin
                    phase_next = PH_IDLE;
                    if (item.metadata_length > 8'(META_MAX))
                    begin
                        cmd_push        = 1'b1;
                        cmd_data.is_err = 1'b1;
                        cmd_data.status = tcfe_pkg::ST_META_LONG;
                    end
                    else if ((item.metadata_length == 8'(META_MAX)) &&
                             (item.text_length != 8'd0))
                    begin
                        cmd_push        = 1'b1;
                        cmd_data.is_err = 1'b1;
                        cmd_data.status = tcfe_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        type_next       = item.event_type;
                        module_next     = item.module_id;
                        total_next      = item.text_length;
                        meta_exp_next   = META_W'(item.metadata_length);
                        meta_cnt_next   = '0;
                        offset_next     = 8'd0;
                        chunk_left_next = '0;
                        if (item.metadata_length != 8'd0)
                            phase_next = PH_META;
                        else if (item.text_length != 8'd0)
                            phase_next = PH_TEXT;
                        else
                        begin
                            // empty message: one frame straight away
                            cmd_push            = 1'b1;
                            cmd_data.do_head    = 1'b1;
                            cmd_data.do_check   = 1'b1;
                            cmd_data.event_type = item.event_type;
                            cmd_data.module_id  = item.module_id;
                            cmd_data.total      = 8'd0;
                            cmd_data.offset     = 8'd0;
                            cmd_data.meta_len   = 8'd0;
                        end
                    end
                end
                tcfe_pkg::KIND_META:
                begin
                    if (phase_reg == PH_META)
                    begin
                        meta_wr.we    = 1'b1;
                        meta_wr.addr  = 8'(meta_cnt_reg);
                        meta_wr.data  = item.data_byte;
                        meta_cnt_next = meta_cnt_inc;
                        if (meta_cnt_inc >= meta_exp_reg)
                        begin
                            if (total_reg != 8'd0)
                                phase_next = PH_TEXT;
                            else
                            begin
                                phase_next        = PH_IDLE;
                                offset_next       = 8'd0;
                                cmd_push          = 1'b1;
                                cmd_data.do_head  = 1'b1;
                                cmd_data.do_check = 1'b1;
                                cmd_data.offset   = 8'd0;
                            end
                        end
                    end
                    else
                    begin
                        cmd_push        = 1'b1;
                        cmd_data.is_err = 1'b1;
                        cmd_data.status = tcfe_pkg::ST_UNEXPECTED;
                    end
                end
                tcfe_pkg::KIND_TEXT:
                begin
                    if (phase_reg == PH_TEXT)
                    begin
                        cmd_push           = 1'b1;
                        cmd_data.do_head   = (chunk_left_reg == '0);
                        cmd_data.chunk     = chunk;
                        cmd_data.has_text  = 1'b1;
                        cmd_data.text_byte = item.data_byte;
                        cmd_data.do_check  = (cl_after == '0);
                        chunk_left_next    = cl_after;
                        offset_next        = offset_inc[7:0];
                        if ((cl_after == '0) && (offset_inc >= {1'b0, total_reg}))
                            phase_next = PH_IDLE;
                    end
                    else
                    begin
                        cmd_push        = 1'b1;
                        cmd_data.is_err = 1'b1;
                        cmd_data.status = tcfe_pkg::ST_UNEXPECTED;
                    end
                end
                default:
                begin
                    cmd_push        = 1'b1;
                    cmd_data.is_err = 1'b1;
                    cmd_data.status = tcfe_pkg::ST_UNEXPECTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            type_reg       <= 8'd0;
            module_reg     <= 8'd0;
            total_reg      <= 8'd0;
            meta_exp_reg   <= '0;
            meta_cnt_reg   <= '0;
            offset_reg     <= 8'd0;
            chunk_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            module_reg     <= module_next;
            total_reg      <= total_next;
            meta_exp_reg   <= meta_exp_next;
            meta_cnt_reg   <= meta_cnt_next;
            offset_reg     <= offset_next;
            chunk_left_reg <= chunk_left_next;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_meta_write_safe: assert property (@(posedge clk) disable iff (!rst_n)
        meta_wr.we |-> (phase_reg == PH_META) && (meta_cnt_reg < meta_exp_reg)
                       && q_empty && back_idle)
        else $error("metadata written while it may still be read");

endmodule

// ===== rtl/tcfe_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_cmd_fifo: command queue
// Short queue of frame commands between the classifier and the emitter.
// ----------------------------------------------------------------------------
module tcfe_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tcfe_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output tcfe_pkg::cmd_t rd_data,
    output logic           q_full,
    output logic           q_empty
);

    localparam int PW = tcfe_pkg::CMDQ_PTR_W;

    tcfe_pkg::cmd_t  entries [tcfe_pkg::CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign q_full  = (count_reg == (PW+1)'(tcfe_pkg::CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (PW+1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

endmodule

// ===== rtl/tcfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_back: frame emitter
// Holds the metadata store and turns each command into frame bytes, one
// per cycle while its registered output stage has room; running XOR checksum.
// ----------------------------------------------------------------------------
module tcfe_back #(
    parameter int FRAME_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tcfe_pkg::meta_wr_t meta_wr,
    input  logic               q_empty,
    input  tcfe_pkg::cmd_t     q_data,
    output logic               q_pop,
    output logic               back_idle,
    output logic               empty,
    input  logic               pop,
    output tcfe_pkg::result_t  result
);

    localparam int META_MAX = FRAME_BYTES - 9;
    localparam int META_IW  = (META_MAX > 1) ? $clog2(META_MAX) : 1;
    localparam int IDX_W    = $clog2(FRAME_BYTES);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_HEAD  = 3'd1;
    localparam logic [2:0] B_TEXT  = 3'd2;
    localparam logic [2:0] B_CHECK = 3'd3;
    localparam logic [2:0] B_ERR   = 3'd4;

    logic [7:0]        meta_store [META_MAX];

    logic [2:0]        state_reg, state_next;
    tcfe_pkg::cmd_t    cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        check_reg, check_next;
    tcfe_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic [7:0]        meta_rd_reg;

    logic              slot_free;
    logic              emit;
    tcfe_pkg::result_t emit_data;
    logic [IDX_W-1:0]  head_last;
    logic [META_IW-1:0] meta_idx;
    logic              meta_rd_en;
    logic [7:0]        head_byte;

    assign slot_free = !out_valid_reg || pop;
    assign back_idle = (state_reg == B_IDLE);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    assign head_last = IDX_W'(tcfe_pkg::HEAD_BYTES) + IDX_W'(cmd_reg.meta_len) - IDX_W'(1);

    // metadata is registered ahead of use, read at the index the header moves to
    assign meta_idx   = META_IW'(idx_next - IDX_W'(tcfe_pkg::HEAD_BYTES));
    assign meta_rd_en = (idx_next >= IDX_W'(tcfe_pkg::HEAD_BYTES)) && (idx_next <= head_last);

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): head_byte = tcfe_pkg::MAGIC_BYTE;
            IDX_W'(1): head_byte = tcfe_pkg::VERSION_BYTE;
            IDX_W'(2): head_byte = cmd_reg.event_type;
            IDX_W'(3): head_byte = tcfe_pkg::HEADER_FIELDS + cmd_reg.meta_len + cmd_reg.chunk;
            IDX_W'(4): head_byte = cmd_reg.module_id;
            IDX_W'(5): head_byte = cmd_reg.offset;
            IDX_W'(6): head_byte = cmd_reg.total;
            IDX_W'(7): head_byte = cmd_reg.chunk;
            default:   head_byte = meta_rd_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        check_next = check_reg;
        emit       = 1'b0;
        emit_data  = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_data;
                    idx_next = '0;
                    if (q_data.is_err)
                        state_next = B_ERR;
                    else if (q_data.do_head)
                    begin
                        state_next = B_HEAD;
                        check_next = 8'd0;
                    end
                    else if (q_data.has_text)
                        state_next = B_TEXT;
                    else
                        state_next = B_CHECK;
                end
            end
            B_HEAD:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    emit_data.frame_byte = head_byte;
                    check_next           = check_reg ^ head_byte;
                    idx_next             = idx_reg + IDX_W'(1);
                    if (idx_reg == head_last)
                        state_next = cmd_reg.has_text ? B_TEXT : B_CHECK;
                end
            end
            B_TEXT:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    emit_data.frame_byte = cmd_reg.text_byte;
                    emit_data.last       = !cmd_reg.do_check;
                    check_next           = check_reg ^ cmd_reg.text_byte;
                    state_next           = cmd_reg.do_check ? B_CHECK : B_IDLE;
                end
            end
            B_CHECK:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    emit_data.frame_byte = check_reg;
                    emit_data.frame_end  = 1'b1;
                    emit_data.last       = 1'b1;
                    check_next           = 8'd0;
                    state_next           = B_IDLE;
                end
            end
            B_ERR:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_data.status = cmd_reg.status;
                    emit_data.last   = 1'b1;
                    state_next       = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_wr.we)
            meta_store[META_IW'(meta_wr.addr)] <= meta_wr.data;
        if (meta_rd_en)
            meta_rd_reg <= meta_store[meta_idx];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (emit)
            out_reg <= emit_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            check_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            check_reg <= check_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    a_end_is_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |->
            (out_reg.last && (out_reg.status == tcfe_pkg::ST_OK)))
        else $error("checksum byte not closing an ok result");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != tcfe_pkg::ST_OK)) |->
            (out_reg.last && (out_reg.frame_byte == 8'd0) && !out_reg.frame_end))
        else $error("error result malformed");

    a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_CHECK) && slot_free) |=>
            ((state_reg == B_IDLE) && (check_reg == 8'd0)))
        else $error("emitter did not close frame after checksum");

endmodule

// ===== dv/text_chunk_frame_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_chunk_frame_encoder_tb: self-checking bench for the frame encoder
// Drives start, metadata and text items through the push side and checks
// every popped frame byte against an in-bench encoder model. Both sides
// pause at random. The run covers a directed opening and then random messages
// mixed with noise.
// ----------------------------------------------------------------------------
module text_chunk_frame_encoder_tb;

    localparam int FRAME_BYTES = 32;
    localparam int META_MAX    = FRAME_BYTES - 9;   // metadata room in a frame
    localparam int ITEM_TARGET = 360;
    localparam int IDLE_PCT    = 13;
    localparam int STALL_LIMIT = 4000;               // cycles with no transfer
    localparam int TAIL_CYCLES = 2 * FRAME_BYTES + 16;
    localparam int PRINT_CAP   = 40;

    // the package names three kinds; the fourth is always rejected
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef enum logic [1:0] {MSG_IDLE, MSG_META, MSG_TEXT} msg_phase_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              pop   = 1'b0;
    tcfe_pkg::item_t   item  = '0;
    logic              full;
    logic              empty;
    tcfe_pkg::result_t result;

    text_chunk_frame_encoder #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Encoder model state: mirrors what the block holds between items.
    // ------------------------------------------------------------------------
    logic [7:0] meta_mem [META_MAX];
    msg_phase_t msg_phase;
    logic [7:0] hold_type;
    logic [7:0] hold_module;
    logic [7:0] text_total;
    logic [7:0] text_pos;
    logic [7:0] frame_xor;
    logic [4:0] meta_len;
    logic [4:0] meta_seen;
    logic [4:0] chunk_rem;

    tcfe_pkg::result_t burst [$];        // bytes caused by the item being encoded
    tcfe_pkg::result_t frames_due [$];   // expected results, oldest first
    tcfe_pkg::item_t   items_pending [$];

    int  mismatches  = 0;
    int  items_taken = 0;
    int  quiet_cycles = 0;
    logic took_item = 1'b0;
    tcfe_pkg::result_t want;

    // no idling on either side while this window of items goes through
    wire calm = (items_taken >= 120) && (items_taken < 200);

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic put_byte(input logic [7:0] b, input logic is_end, input logic [1:0] st);
        tcfe_pkg::result_t r;
        r.frame_byte = b;
        r.frame_end  = is_end;
        r.status     = st;
        r.last       = 1'b0;
        burst.push_back(r);
    endtask

    task automatic put_body(input logic [7:0] b);
        frame_xor = frame_xor ^ b;
        put_byte(b, 1'b0, tcfe_pkg::ST_OK);
    endtask

    task automatic put_checksum();
        put_byte(frame_xor, 1'b1, tcfe_pkg::ST_OK);
        frame_xor = '0;
    endtask

    // everything in front of the chunk text; metadata repeats in each frame
    task automatic put_header(input logic [7:0] chunk);
        frame_xor = '0;
        put_body(tcfe_pkg::MAGIC_BYTE);
        put_body(tcfe_pkg::VERSION_BYTE);
        put_body(hold_type);
        put_body(8'(tcfe_pkg::HEADER_FIELDS + meta_len + chunk));
        put_body(hold_module);
        put_body(text_pos);
        put_body(text_total);
        put_body(chunk);
        for (int i = 0; i < meta_len; i++)
            put_body(meta_mem[i]);
    endtask

    // a message without text still goes out as one frame with chunk length 0
    task automatic put_empty_message();
        text_pos = '0;
        put_header(8'h00);
        put_checksum();
        msg_phase = MSG_IDLE;
    endtask

    // Work out the frame bytes one accepted item causes and queue them.
    task automatic encode_item(input tcfe_pkg::item_t it);
        int                room;
        int                rest;
        logic [7:0]        chunk;
        tcfe_pkg::result_t r;
        burst.delete();
        if (it.kind == tcfe_pkg::KIND_START)
        begin
            // a start always wins, even halfway through a frame
            msg_phase = MSG_IDLE;
            if (it.metadata_length > META_MAX)
            begin
                put_byte(8'h00, 1'b0, tcfe_pkg::ST_META_LONG);
            end
            else if (it.metadata_length == META_MAX && it.text_length != 0)
            begin
                put_byte(8'h00, 1'b0, tcfe_pkg::ST_NO_ROOM);
            end
            else
            begin
                hold_type   = it.event_type;
                hold_module = it.module_id;
                text_total  = it.text_length;
                meta_len    = 5'(it.metadata_length);
                meta_seen   = '0;
                text_pos    = '0;
                chunk_rem   = '0;
                frame_xor   = '0;
                if (it.metadata_length != 0)
                    msg_phase = MSG_META;
                else if (it.text_length != 0)
                    msg_phase = MSG_TEXT;
                else
                    put_empty_message();
            end
        end
        else if (it.kind == tcfe_pkg::KIND_META && msg_phase == MSG_META)
        begin
            meta_mem[meta_seen] = it.data_byte;
            meta_seen++;
            if (meta_seen >= meta_len)
            begin
                if (text_total != 0)
                    msg_phase = MSG_TEXT;
                else
                    put_empty_message();
            end
        end
        else if (it.kind == tcfe_pkg::KIND_TEXT && msg_phase == MSG_TEXT)
        begin
            // first text byte of a chunk releases the whole header
            if (chunk_rem == 0)
            begin
                room  = META_MAX - meta_len;
                rest  = text_total - text_pos;
                chunk = 8'((rest < room) ? rest : room);
                put_header(chunk);
                chunk_rem = 5'(chunk);
            end
            put_body(it.data_byte);
            if (chunk_rem != 0)
                chunk_rem--;
            text_pos++;
            if (chunk_rem == 0)
            begin
                put_checksum();
                if (text_pos >= text_total)
                    msg_phase = MSG_IDLE;
            end
        end
        else
        begin
            // wrong kind for the phase, or kind 3: flagged, state untouched
            put_byte(8'h00, 1'b0, tcfe_pkg::ST_UNEXPECTED);
        end
        for (int i = 0; i < burst.size(); i++)
        begin
            r      = burst[i];
            r.last = (i == burst.size() - 1);
            frames_due.push_back(r);
        end
    endtask

    // unused fields carry random values so that every input bit toggles
    task automatic add_start(input logic [7:0] etype, input logic [7:0] mod,
                             input logic [7:0] tlen, input logic [7:0] mlen);
        tcfe_pkg::item_t it;
        it.kind            = tcfe_pkg::KIND_START;
        it.event_type      = etype;
        it.module_id       = mod;
        it.text_length     = tlen;
        it.metadata_length = mlen;
        it.data_byte       = 8'($urandom);
        items_pending.push_back(it);
    endtask

    task automatic add_byte(input logic [1:0] kind, input logic [7:0] b);
        tcfe_pkg::item_t it;
        it.kind            = kind;
        it.event_type      = 8'($urandom);
        it.module_id       = 8'($urandom);
        it.text_length     = 8'($urandom);
        it.metadata_length = 8'($urandom);
        it.data_byte       = b;
        items_pending.push_back(it);
    endtask

    // ------------------------------------------------------------------------
    // Driver: pushes the oldest pending item, holds it until the transfer.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || took_item)
            begin
                if (items_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    push <= 1'b1;
                    item <= items_pending[0];
                end
                else
                begin
                    push <= 1'b0;
                end
            end
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each item transfer, checks each result transfer,
    // and watches for the block going quiet with work outstanding.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_item <= push && !full;
            if (push && !full)
            begin
                encode_item(item);
                void'(items_pending.pop_front());
                items_taken++;
            end
            if (pop && !empty)
            begin
                if (frames_due.size() == 0)
                begin
                    flag_mismatch($sformatf("byte %02h st %0d with nothing expected",
                                            result.frame_byte, result.status));
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (result.frame_byte !== want.frame_byte)
                        flag_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                result.frame_byte, want.frame_byte));
                    if (result.frame_end !== want.frame_end)
                        flag_mismatch($sformatf("frame_end %b, expected %b",
                                                result.frame_end, want.frame_end));
                    if (result.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                result.status, want.status));
                    if (result.last !== want.last)
                        flag_mismatch($sformatf("last %b, expected %b",
                                                result.last, want.last));
                end
            end
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (items_pending.size() != 0 || frames_due.size() != 0)
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int pick;
        int ml;
        int tl;
        int cut;

        msg_phase   = MSG_IDLE;
        hold_type   = '0;
        hold_module = '0;
        text_total  = '0;
        text_pos    = '0;
        frame_xor   = '0;
        meta_len    = '0;
        meta_seen   = '0;
        chunk_rem   = '0;
        for (int i = 0; i < META_MAX; i++)
            meta_mem[i] = '0;

        // directed opening
        add_start(8'hFF, 8'hFF, 8'h00, 8'h00);          // no text, no metadata
        add_byte(KIND_BAD, 8'hFF);                      // kind 3
        add_byte(tcfe_pkg::KIND_META, 8'h12);           // metadata while idle
        add_byte(tcfe_pkg::KIND_TEXT, 8'h34);           // text while idle
        add_start(8'h00, 8'h00, 8'hFF, 8'hFF);          // metadata far too long
        add_start(8'h5A, 8'hC3, 8'h80, 8'(META_MAX + 1)); // one over the room
        add_start(8'h11, 8'h22, 8'h01, 8'(META_MAX));   // metadata fills the frame
        add_start(8'h7E, 8'h81, 8'h02, 8'h02);
        add_byte(tcfe_pkg::KIND_META, 8'hFF);
        add_byte(tcfe_pkg::KIND_TEXT, 8'hEE);           // text during metadata
        add_byte(tcfe_pkg::KIND_META, 8'h00);
        add_byte(tcfe_pkg::KIND_META, 8'h99);           // metadata during text
        add_byte(tcfe_pkg::KIND_TEXT, 8'hAA);           // first of a two-byte chunk
        add_start(8'hC0, 8'h03, 8'h01, 8'h00);          // abandons that frame
        add_byte(tcfe_pkg::KIND_TEXT, 8'h55);
        add_start(8'h40, 8'h04, 8'h00, 8'h01);          // empty text after metadata
        add_byte(tcfe_pkg::KIND_META, 8'h7F);

        // random part: mostly complete messages, some cut short, some noise
        while (items_pending.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: ml = $urandom_range(3);
                    5, 6, 7:       ml = $urandom_range(22, 4);
                    8:             ml = META_MAX - 1;
                    default:       ml = META_MAX;
                endcase
                case ($urandom_range(9))
                    0, 1:    tl = 0;
                    8:       tl = $urandom_range(50, 13);
                    9:       tl = 1;
                    default: tl = $urandom_range(12, 1);
                endcase
                if (ml == META_MAX)
                    tl = 0;
                cut = ($urandom_range(9) == 0) ? $urandom_range(ml + tl) : ml + tl;
                add_start(8'($urandom), 8'($urandom), 8'(tl), 8'(ml));
                for (int k = 0; k < cut; k++)
                    add_byte((k < ml) ? tcfe_pkg::KIND_META : tcfe_pkg::KIND_TEXT,
                             8'($urandom));
            end
            else if (pick < 88)
            begin
                if ($urandom_range(1) == 0)
                    add_start(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)),
                              8'(META_MAX));
                else
                    add_start(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom_range(255, META_MAX + 1)));
            end
            else
            begin
                add_byte(2'($urandom_range(3)), 8'($urandom));
                if (items_pending[$].kind == tcfe_pkg::KIND_START)
                    items_pending[$].data_byte = 8'($urandom);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_pending.size() != 0 || frames_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && frames_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
